// ===== rtl/core/fenwick_kth_smallest_defines.svh =====
// Assertion macros used by the RTL that checks itself.
`ifndef FENWICK_KTH_SMALLEST_DEFINES_SVH
`define FENWICK_KTH_SMALLEST_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is high.
`define FKS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fenwick_kth_smallest: assertion failed");
// Clocked check that also holds during reset.
`define FKS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("fenwick_kth_smallest: assertion failed");
`else
`define FKS_ASSERT(label, clk, rst, prop)
`define FKS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/fks_pkg.sv =====
package fks_pkg;

   localparam int VAL_BITS  = 10;
   localparam int RANK_BITS = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [VAL_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [VAL_BITS-1:0] kth_value;
      logic                rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_CNT,
      RD_UPD,
      RD_SRCH
   } rd_sel_type;

   typedef struct packed {
      logic       clr_write;
      logic       load;
      logic       reject;
      logic       cnt_first;
      logic       cnt_next;
      logic       upd_write;
      logic       commit;
      logic       srch_init;
      logic       srch_take;
      logic       step_shift;
      logic       rsp_load;
      rd_sel_type rd_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic bad_range;
      logic full;
      logic is_remove;
      logic y_eq_z;
      logic count_zero;
      logic j_next_ok;
      logic srch_ok;
      logic step_fits;
      logic step_last;
      logic rsp_free;
   } ctrl_stat_type;

endpackage

// ===== rtl/core/fenwick_kth_smallest.sv =====
// Order-statistic store over a multiset of value indices, kept as a binary
// indexed tree of counts in one RAM.
// req channel: one transfer carries cmd (insert or remove one copy) and value.
// rsp channel: exactly one transfer per request: found, kth_value, rejected.
//   kth_value is the least value whose prefix count reaches kth_rank, or 0.
// csr port: csr_we writes csr_wdata into kth_rank (reset value 1); write only
//   while no request is in flight.
// Flow: one request at a time. Each tree node is a registered RAM read,
//   then use or write back. The update touches U nodes, the presence check
//   of a removal subtracts R nodes and the search takes S steps; U + R and S
//   are each at most log2(VALUE_COUNT)+1.
// The RAM port carries all tree traffic, so it sets the pace of a request.
// Reset: the block zeroes the tree one entry a cycle, all VALUE_COUNT
//   entries, and holds req_stall high meanwhile; csr writes are taken throughout.
// A result waits in an output register; while rsp_stall is high the block
//   still accepts the next request and holds its result until the slot frees.
`include "fenwick_kth_smallest_defines.svh"

module fenwick_kth_smallest #(
   parameter int VALUE_COUNT = 1024,
   parameter int COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fks_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fks_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [fks_pkg::RANK_BITS-1:0] csr_wdata
);

   fks_pkg::ctrl_cmd_type  cmd;
   fks_pkg::ctrl_stat_type stat;

   // Sequencer: clear pass, update walk, presence check and tree descent.
   fks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tree RAM, walk registers, total, rank register and output slot.
   fks_datapath #(
      .VALUE_COUNT (VALUE_COUNT),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Accepting a request closes the input until its result is loaded.
   `FKS_ASSERT(a_one_in_flight, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // The clear pass and the tree update never write in the same cycle.
   `FKS_ASSERT_ALWAYS(a_wr_excl, clock, !(cmd.clr_write && cmd.upd_write))
   // Loading a result always raises the output valid.
   `FKS_ASSERT(a_rsp_load, clock, reset, cmd.rsp_load |=> rsp_valid)

endmodule

// ===== rtl/core/fks_ram.sv =====
module fks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fks_ctrl.sv =====
module fks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fks_pkg::ctrl_stat_type stat,
   output fks_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      CHECK,
      CNT_RD0,
      CNT_DAT0,
      CNT_RD,
      CNT_DAT,
      UPD_RD,
      UPD_WR,
      SRCH_INIT,
      SRCH_RD,
      SRCH_DAT,
      DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = fks_pkg::RD_UPD;
      state_in = state_ff;
      unique case (state_ff)
         CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            priority if (stat.bad_range || (!stat.is_remove && stat.full)) begin
               cmd.reject = 1'b1;
               state_in   = SRCH_INIT;
            end else if (stat.is_remove) begin
               state_in = CNT_RD0;
            end else begin
               state_in = UPD_RD;
            end
         end
         CNT_RD0: begin
            cmd.rd_sel = fks_pkg::RD_CNT;
            state_in   = CNT_DAT0;
         end
         CNT_DAT0: begin
            cmd.cnt_first = 1'b1;
            state_in      = CNT_RD;
         end
         CNT_RD: begin
            cmd.rd_sel = fks_pkg::RD_CNT;
            priority if (stat.y_eq_z && stat.count_zero) begin
               cmd.reject = 1'b1;
               state_in   = SRCH_INIT;
            end else if (stat.y_eq_z) begin
               state_in = UPD_RD;
            end else begin
               state_in = CNT_DAT;
            end
         end
         CNT_DAT: begin
            cmd.cnt_next = 1'b1;
            state_in     = CNT_RD;
         end
         UPD_RD: begin
            state_in = UPD_WR;
         end
         UPD_WR: begin
            cmd.upd_write = 1'b1;
            if (stat.j_next_ok) begin
               state_in = UPD_RD;
            end else begin
               cmd.commit = 1'b1;
               state_in   = SRCH_INIT;
            end
         end
         SRCH_INIT: begin
            cmd.srch_init = 1'b1;
            state_in      = stat.srch_ok ? SRCH_RD : DONE;
         end
         SRCH_RD: begin
            cmd.rd_sel = fks_pkg::RD_SRCH;
            priority if (stat.step_fits) begin
               state_in = SRCH_DAT;
            end else if (stat.step_last) begin
               state_in = DONE;
            end else begin
               cmd.step_shift = 1'b1;
            end
         end
         SRCH_DAT: begin
            cmd.srch_take = 1'b1;
            if (stat.step_last) begin
               state_in = DONE;
            end else begin
               cmd.step_shift = 1'b1;
               state_in       = SRCH_RD;
            end
         end
         DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/fks_datapath.sv =====
module fks_datapath #(
   parameter int VALUE_COUNT = 1024,
   parameter int COUNT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fks_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [fks_pkg::RANK_BITS-1:0]   csr_wdata,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output fks_pkg::rsp_type                rsp_data,
   input  fks_pkg::ctrl_cmd_type           cmd,
   output fks_pkg::ctrl_stat_type          stat
);

   localparam int IDX_BITS  = $clog2(VALUE_COUNT);
   localparam int J_BITS    = $clog2(VALUE_COUNT + 1);
   localparam int RB        = fks_pkg::RANK_BITS;
   localparam int CMP_BITS  = (COUNT_BITS > RB) ? COUNT_BITS : RB;
   localparam logic [J_BITS-1:0]   TOP_STEP  = J_BITS'(1) << (J_BITS - 1);
   localparam logic [J_BITS:0]     LIMIT     = (J_BITS + 1)'(VALUE_COUNT);
   localparam logic [IDX_BITS-1:0] LAST_ADDR = IDX_BITS'(VALUE_COUNT - 1);

   // control state
   logic [IDX_BITS-1:0]   clr_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [RB-1:0]         kth_rank_ff;
   logic                  rsp_valid_ff;

   // working registers
   fks_pkg::req_type      item_ff;
   fks_pkg::rsp_type      rsp_ff;
   logic [J_BITS-1:0]     j_ff, y_ff, z_ff, pos_ff, step_ff;
   logic [COUNT_BITS-1:0] acc_ff;
   logic [RB-1:0]         rem_ff;
   logic                  found_ff, rejected_ff;

   logic [J_BITS-1:0]     vplus, j_lowbit;
   logic [J_BITS:0]       j_sum, srch_end;
   logic [IDX_BITS-1:0]   rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] rd_data, wr_data, upd_data;
   logic                  wr_en, is_remove, node_lt_rem;

   assign vplus     = J_BITS'(req_data.value) + J_BITS'(1);
   assign j_lowbit  = j_ff & (~j_ff + J_BITS'(1));
   assign j_sum     = {1'b0, j_ff} + {1'b0, j_lowbit};
   assign srch_end  = {1'b0, pos_ff} + {1'b0, step_ff};
   assign is_remove = (item_ff.cmd == fks_pkg::CMD_REMOVE);
   assign upd_data  = is_remove ? (rd_data - COUNT_BITS'(1)) : (rd_data + COUNT_BITS'(1));
   assign node_lt_rem = CMP_BITS'(rd_data) < CMP_BITS'(rem_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         fks_pkg::RD_CNT:  rd_addr = IDX_BITS'(y_ff - J_BITS'(1));
         fks_pkg::RD_SRCH: rd_addr = IDX_BITS'(srch_end - (J_BITS + 1)'(1));
         default:          rd_addr = IDX_BITS'(j_ff - J_BITS'(1));
      endcase
   end

   assign wr_en   = cmd.clr_write | cmd.upd_write;
   assign wr_addr = cmd.clr_write ? clr_ff : IDX_BITS'(j_ff - J_BITS'(1));
   assign wr_data = cmd.clr_write ? '0 : upd_data;

   fks_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (VALUE_COUNT)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.clr_last   = (clr_ff == LAST_ADDR);
      stat.bad_range  = 32'(item_ff.value) >= 32'(VALUE_COUNT);
      stat.full       = &total_ff;
      stat.is_remove  = is_remove;
      stat.y_eq_z     = (y_ff == z_ff);
      stat.count_zero = (acc_ff == '0);
      stat.j_next_ok  = (j_sum <= LIMIT);
      stat.srch_ok    = (kth_rank_ff != '0) &&
                        (CMP_BITS'(total_ff) >= CMP_BITS'(kth_rank_ff));
      stat.step_fits  = (srch_end <= LIMIT);
      stat.step_last  = (step_ff == J_BITS'(1));
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         total_ff     <= '0;
         kth_rank_ff  <= RB'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + IDX_BITS'(1);
         end
         if (cmd.commit) begin
            total_ff <= is_remove ? (total_ff - COUNT_BITS'(1))
                                  : (total_ff + COUNT_BITS'(1));
         end
         if (csr_we) begin
            kth_rank_ff <= csr_wdata;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff     <= req_data;
         j_ff        <= vplus;
         y_ff        <= vplus;
         z_ff        <= vplus & (vplus - J_BITS'(1));
         rejected_ff <= 1'b0;
      end
      if (cmd.reject) begin
         rejected_ff <= 1'b1;
      end
      if (cmd.cnt_first) begin
         acc_ff <= rd_data;
         y_ff   <= y_ff - J_BITS'(1);
      end
      if (cmd.cnt_next) begin
         acc_ff <= acc_ff - rd_data;
         y_ff   <= y_ff & (y_ff - J_BITS'(1));
      end
      if (cmd.upd_write) begin
         j_ff <= J_BITS'(j_sum);
      end
      if (cmd.srch_init) begin
         pos_ff   <= '0;
         step_ff  <= TOP_STEP;
         rem_ff   <= kth_rank_ff;
         found_ff <= stat.srch_ok;
      end
      if (cmd.srch_take && node_lt_rem) begin
         pos_ff <= J_BITS'(srch_end);
         rem_ff <= RB'(CMP_BITS'(rem_ff) - CMP_BITS'(rd_data));
      end
      if (cmd.step_shift) begin
         step_ff <= step_ff >> 1;
      end
      if (cmd.rsp_load) begin
         rsp_ff.found     <= found_ff;
         rsp_ff.kth_value <= fks_pkg::VAL_BITS'(pos_ff);
         rsp_ff.rejected  <= rejected_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
